FILE: design/planar_shadow_matrix_assert.svh
// assertion macros used by the rtl of the shadow matrix block
`ifndef PLANAR_SHADOW_MATRIX_ASSERT_SVH
`define PLANAR_SHADOW_MATRIX_ASSERT_SVH

// condition holds in the same cycle
`define PSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shadow matrix check failed");

// condition holds in the following cycle
`define PSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shadow matrix check failed");

`endif

FILE: design/psm_pkg.sv
`default_nettype none

package psm_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TR_W   = 32;
  localparam int unsigned HGT_W  = 20;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned FRAC_W = 12;
  localparam int unsigned NUM_W  = HGT_W;
  localparam int unsigned DVD_W  = NUM_W + FRAC_W;
  localparam int unsigned ACC_W  = TR_W + FRAC_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W);

  localparam logic [1:0] REQ_LIGHT  = 2'd0;
  localparam logic [1:0] REQ_COLUMN = 2'd1;
  localparam logic [1:0] REQ_TRANS  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic signed [VAL_W-1:0] val_c;
    logic signed [TR_W-1:0]  trans_x;
    logic signed [TR_W-1:0]  trans_y;
    logic signed [TR_W-1:0]  trans_z;
    logic signed [HGT_W-1:0] height;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] res_top;
    logic signed [VAL_W-1:0] res_mid;
    logic signed [VAL_W-1:0] res_bottom;
    logic signed [TR_W-1:0]  res_tx;
    logic signed [TR_W-1:0]  res_ty;
    logic signed [TR_W-1:0]  res_tz;
    logic                    res_kind;
    logic                    last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/psm_div_mac.sv
`default_nettype none

// restoring divider, one quotient bit a cycle msb first; each bit is folded
// straight into two shift-add accumulators, so the products finish with it
module psm_div_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [psm_pkg::DVD_W-1:0] dividend,
  input  logic [psm_pkg::SUM_W-1:0] divisor,
  input  logic [psm_pkg::SUM_W-1:0] mag_x,
  input  logic [psm_pkg::SUM_W-1:0] mag_z,
  output logic                       done,
  output logic [psm_pkg::ACC_W-1:0] prod_x,
  output logic [psm_pkg::ACC_W-1:0] prod_z
);

  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [psm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [psm_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [psm_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [psm_pkg::SUM_W-1:0]  dsr_r, dsr_nxt;
  logic [psm_pkg::SUM_W-1:0]  mx_r, mx_nxt;
  logic [psm_pkg::SUM_W-1:0]  mz_r, mz_nxt;
  logic [psm_pkg::ACC_W-1:0]  px_r, px_nxt;
  logic [psm_pkg::ACC_W-1:0]  pz_r, pz_nxt;
  logic [psm_pkg::SUM_W:0]    rem_sh;
  logic [psm_pkg::SUM_W:0]    rem_sub;
  logic                       qbit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[psm_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    qbit    = (rem_sh >= {1'b0, dsr_r});

    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    mx_nxt   = mx_r;
    mz_nxt   = mz_r;
    px_nxt   = px_r;
    pz_nxt   = pz_r;

    if (load) begin
      run_nxt = 1'b1;
      cnt_nxt = psm_pkg::CNT_W'(psm_pkg::DVD_W - 1);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      mx_nxt  = mag_x;
      mz_nxt  = mag_z;
      px_nxt  = '0;
      pz_nxt  = '0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[psm_pkg::DVD_W-2:0], 1'b0};
      rem_nxt = qbit ? rem_sub[psm_pkg::SUM_W-1:0] : rem_sh[psm_pkg::SUM_W-1:0];
      px_nxt  = {px_r[psm_pkg::ACC_W-2:0], 1'b0}
              + (qbit ? psm_pkg::ACC_W'(mx_r) : '0);
      pz_nxt  = {pz_r[psm_pkg::ACC_W-2:0], 1'b0}
              + (qbit ? psm_pkg::ACC_W'(mz_r) : '0);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    mx_r  <= mx_nxt;
    mz_r  <= mz_nxt;
    px_r  <= px_nxt;
    pz_r  <= pz_nxt;
  end

  assign done   = done_r;
  assign prod_x = px_r;
  assign prod_z = pz_r;

endmodule

`default_nettype wire

FILE: design/planar_shadow_matrix.sv
// light row: taken while busy stays low, no result.
// column or translation with sum_y negative: the accepting edge loads the
// 32-step bit-serial divide/accumulate unit; its done flag, then the strobe, are registered.
// column or translation with sum_y not negative: ST_FIN, then the registered strobe.
// a new transaction is taken in the strobe cycle; the receiver cannot stall.
// synchronous active-low reset clears the sums, the sequencer and the strobe.
`default_nettype none
`include "planar_shadow_matrix_assert.svh"

module planar_shadow_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  psm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output psm_pkg::out_item_t out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [psm_pkg::SUM_W-1:0]  sum_x_r, sum_x_nxt;
  logic [psm_pkg::SUM_W-1:0]  sum_y_r, sum_y_nxt;
  logic [psm_pkg::SUM_W-1:0]  sum_z_r, sum_z_nxt;
  logic                       shear_r, shear_nxt;
  logic                       out_valid_r, out_valid_nxt;
  psm_pkg::in_item_t          in_r, in_nxt;
  psm_pkg::out_item_t         out_r, out_nxt;

  logic                       accept;
  logic                       sy_neg;
  logic                       div_load;
  logic                       div_done;
  logic                       fin;
  logic [psm_pkg::NUM_W-1:0]  num;
  logic [psm_pkg::NUM_W-1:0]  num_mag;
  logic [psm_pkg::SUM_W-1:0]  mag_x, mag_z, mag_y;
  logic [psm_pkg::ACC_W-1:0]  prod_x, prod_z;
  logic                       is_trans;
  logic                       num_neg;
  logic                       x_neg, z_neg;
  logic [psm_pkg::TR_W-1:0]   adj_x, adj_z;
  logic [psm_pkg::TR_W-1:0]   base_x, base_z;
  logic [psm_pkg::TR_W-1:0]   new_x, new_z;
  logic [psm_pkg::TR_W-1:0]   new_y;

  assign accept = start && !busy;
  assign sy_neg = sum_y_r[psm_pkg::SUM_W-1];

  // shear numerator: column middle, or the plane height
  assign num     = (in_item.req_type == psm_pkg::REQ_TRANS) ? in_item.height
                 : {{(psm_pkg::NUM_W - psm_pkg::VAL_W){in_item.val_b[psm_pkg::VAL_W-1]}},
                    in_item.val_b};
  assign num_mag = num[psm_pkg::NUM_W-1] ? (~num + 1'b1) : num;
  assign mag_x   = sum_x_r[psm_pkg::SUM_W-1] ? (~sum_x_r + 1'b1) : sum_x_r;
  assign mag_y   = ~sum_y_r + 1'b1;
  assign mag_z   = sum_z_r[psm_pkg::SUM_W-1] ? (~sum_z_r + 1'b1) : sum_z_r;

  assign div_load = accept && sy_neg
                 && ((in_item.req_type == psm_pkg::REQ_COLUMN)
                  || (in_item.req_type == psm_pkg::REQ_TRANS));

  psm_div_mac u_div_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend ({num_mag, {psm_pkg::FRAC_W{1'b0}}}),
    .divisor  (mag_y),
    .mag_x    (mag_x),
    .mag_z    (mag_z),
    .done     (div_done),
    .prod_x   (prod_x),
    .prod_z   (prod_z)
  );

  assign fin      = (state_r == ST_FIN) || ((state_r == ST_DIV) && div_done);
  assign is_trans = (in_r.req_type == psm_pkg::REQ_TRANS);
  assign num_neg  = is_trans ? in_r.height[psm_pkg::HGT_W-1]
                             : in_r.val_b[psm_pkg::VAL_W-1];

  // k takes the opposite sign of the numerator since sum_y is negative
  assign x_neg = sum_x_r[psm_pkg::SUM_W-1] ^ ~num_neg;
  assign z_neg = sum_z_r[psm_pkg::SUM_W-1] ^ ~num_neg;
  assign adj_x = shear_r ? prod_x[psm_pkg::ACC_W-1:psm_pkg::FRAC_W] : '0;
  assign adj_z = shear_r ? prod_z[psm_pkg::ACC_W-1:psm_pkg::FRAC_W] : '0;

  assign base_x = is_trans ? in_r.trans_x
                : {{(psm_pkg::TR_W - psm_pkg::VAL_W){in_r.val_a[psm_pkg::VAL_W-1]}},
                   in_r.val_a};
  assign base_z = is_trans ? in_r.trans_z
                : {{(psm_pkg::TR_W - psm_pkg::VAL_W){in_r.val_c[psm_pkg::VAL_W-1]}},
                   in_r.val_c};
  assign new_x  = x_neg ? (base_x + adj_x) : (base_x - adj_x);
  assign new_z  = z_neg ? (base_z + adj_z) : (base_z - adj_z);
  assign new_y  = in_r.trans_y
                - {{(psm_pkg::TR_W - psm_pkg::HGT_W){in_r.height[psm_pkg::HGT_W-1]}},
                   in_r.height};

  always_comb begin
    state_nxt     = state_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_z_nxt     = sum_z_r;
    shear_nxt     = shear_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = fin;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.req_type)
            psm_pkg::REQ_LIGHT: begin
              sum_x_nxt = sum_x_r + psm_pkg::SUM_W'(in_item.val_a);
              sum_y_nxt = sum_y_r + psm_pkg::SUM_W'(in_item.val_b);
              sum_z_nxt = sum_z_r + psm_pkg::SUM_W'(in_item.val_c);
            end
            psm_pkg::REQ_COLUMN, psm_pkg::REQ_TRANS: begin
              in_nxt    = in_item;
              shear_nxt = sy_neg;
              state_nxt = sy_neg ? ST_DIV : ST_FIN;
            end
            psm_pkg::REQ_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      out_nxt = '0;
      if (is_trans) begin
        out_nxt.res_tx   = new_x;
        out_nxt.res_ty   = new_y;
        out_nxt.res_tz   = new_z;
        out_nxt.res_kind = 1'b1;
        out_nxt.last     = 1'b1;
        sum_x_nxt        = '0;
        sum_y_nxt        = '0;
        sum_z_nxt        = '0;
      end else begin
        out_nxt.res_top    = new_x[psm_pkg::VAL_W-1:0];
        out_nxt.res_bottom = new_z[psm_pkg::VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      shear_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      shear_r     <= shear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `PSM_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `PSM_ASSERT_NEXT(a_light_no_busy,
    accept && (in_item.req_type == psm_pkg::REQ_LIGHT), !busy)
  `PSM_ASSERT_SAME(a_last_clears_sums, out_valid && out_item.last,
    (sum_x_r == '0) && (sum_y_r == '0) && (sum_z_r == '0))
  `PSM_ASSERT_SAME(a_mid_zero, out_valid, out_item.res_mid == '0)

endmodule

`default_nettype wire

FILE: bench/tb_planar_shadow_matrix.sv
`timescale 1ns / 1ps

module tb_planar_shadow_matrix;
  import psm_pkg::*;

  // predicts the shadow matrix results and checks them in arrival order
  class shadow_tracker;
    logic signed [SUM_W-1:0] acc_x;
    logic signed [SUM_W-1:0] acc_y;
    logic signed [SUM_W-1:0] acc_z;
    out_item_t pending_shadows[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned sheared_count;
    int unsigned ignored_count;

    function new();
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      mismatches = 0;
      results_seen = 0;
      sheared_count = 0;
      ignored_count = 0;
    endfunction

    // trunc(s * k / 4096) with k = trunc((num << 12) / sy)
    function longint shear_term(longint s, longint num, longint sy);
      longint k;
      k = (num * 4096) / sy;
      return (s * k) / 4096;
    endfunction

    function void note_item(in_item_t it);
      out_item_t shadow;
      longint top;
      longint bot;
      longint tx;
      longint ty;
      longint tz;
      longint h;
      shadow = '0;
      case (it.req_type)
        REQ_LIGHT: begin
          acc_x = acc_x + it.val_a;
          acc_y = acc_y + it.val_b;
          acc_z = acc_z + it.val_c;
        end
        REQ_COLUMN: begin
          top = it.val_a;
          bot = it.val_c;
          if (acc_y < 0) begin
            top -= shear_term(acc_x, it.val_b, acc_y);
            bot -= shear_term(acc_z, it.val_b, acc_y);
            sheared_count++;
          end
          shadow.res_top = top[VAL_W-1:0];
          shadow.res_bottom = bot[VAL_W-1:0];
          pending_shadows.push_back(shadow);
        end
        REQ_TRANS: begin
          tx = it.trans_x;
          ty = it.trans_y;
          tz = it.trans_z;
          h = it.height;
          if (acc_y < 0) begin
            tx -= shear_term(acc_x, h, acc_y);
            tz -= shear_term(acc_z, h, acc_y);
            sheared_count++;
          end
          ty -= h;
          shadow.res_tx = tx[TR_W-1:0];
          shadow.res_ty = ty[TR_W-1:0];
          shadow.res_tz = tz[TR_W-1:0];
          shadow.res_kind = 1'b1;
          shadow.last = 1'b1;
          pending_shadows.push_back(shadow);
          acc_x = '0;
          acc_y = '0;
          acc_z = '0;
        end
        default: ignored_count++;
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch: %s", what);
    endtask

    task compare_field(string name, logic signed [63:0] got_v, logic signed [63:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d field %s got %0d want %0d", results_seen, name,
                         got_v, want_v));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_shadows.size() == 0) begin
        report($sformatf("result %0d (kind %0d) with nothing outstanding", results_seen,
                         got.res_kind));
        return;
      end
      want = pending_shadows.pop_front();
      compare_field("res_top", got.res_top, want.res_top);
      compare_field("res_mid", got.res_mid, want.res_mid);
      compare_field("res_bottom", got.res_bottom, want.res_bottom);
      compare_field("res_tx", got.res_tx, want.res_tx);
      compare_field("res_ty", got.res_ty, want.res_ty);
      compare_field("res_tz", got.res_tz, want.res_tz);
      compare_field("res_kind", got.res_kind, want.res_kind);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_valid;
  out_item_t out_item;

  shadow_tracker book = new();
  int unsigned items_sent = 0;
  bit no_idle = 1'b0;

  planar_shadow_matrix DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      book.check_result(out_item);
  end

  // holds the transaction until it is taken, then perhaps idles a while
  task send_item(input in_item_t it);
    int unsigned gap;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    book.note_item(it);
    items_sent++;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_fields(input logic [1:0] kind, input logic signed [15:0] a, b, c,
                   input logic signed [31:0] tx, ty, tz, input logic signed [19:0] h);
    in_item_t it;
    it.req_type = kind;
    it.val_a = a;
    it.val_b = b;
    it.val_c = c;
    it.trans_x = tx;
    it.trans_y = ty;
    it.trans_z = tz;
    it.height = h;
    send_item(it);
  endtask

  task pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (book.pending_shadows.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'($urandom_range(0, 8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [19:0] pick_height();
    case ($urandom_range(0, 7))
      0: return 20'sh7ffff;
      1: return 20'sh80000;
      2: return 20'($urandom_range(0, 8191)) - 20'sd4096;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] kind);
    in_item_t it;
    it.req_type = kind;
    it.val_a = pick_val();
    it.val_b = pick_val();
    it.val_c = pick_val();
    it.trans_x = $urandom;
    it.trans_y = $urandom;
    it.trans_z = $urandom;
    it.height = pick_height();
    // light rows mostly pull sum_y negative so that the shear path is exercised
    if (kind == REQ_LIGHT && $urandom_range(0, 3) != 0)
      it.val_b = 16'($urandom) | 16'h8000;
    return it;
  endfunction

  initial begin
    int unsigned n_rows;
    int unsigned n_cols;
    int unsigned seq_count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sums still zero: no shear
    send_fields(REQ_COLUMN, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
    send_fields(REQ_TRANS, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 20'sh80000);
    send_fields(REQ_TRANS, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 20'sh7ffff);
    send_fields(REQ_NONE, 16'shffff, 16'shffff, 16'shffff, -1, -1, -1, -1);
    // sum_y of minus one gives the largest slope
    send_fields(REQ_LIGHT, 16'sh7fff, -16'sd1, 16'sh8000, 0, 0, 0, 0);
    send_fields(REQ_LIGHT, 0, 0, 0, 0, 0, 0, 0);
    send_fields(REQ_LIGHT, 0, 0, 0, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 0, 16'sh7fff, 0, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 1, 0, -1, 0, 0, 0, 0);
    send_fields(REQ_TRANS, 0, 0, 0, 32'sh7fffffff, 0, 32'sh80000000, 20'sh80000);
    // extra light rows wrap sum_y round to a positive value
    repeat (5) send_fields(REQ_LIGHT, 0, 16'sh8000, 0, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 1234, 5000, -7, 0, 0, 0, 0);
    send_fields(REQ_LIGHT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    send_fields(REQ_LIGHT, 0, 1, 0, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, 0, 0, 0);
    send_fields(REQ_TRANS, 0, 0, 0, 0, 0, 0, 20'sh7ffff);
    send_fields(REQ_LIGHT, -100, -4096, 200, 0, 0, 0, 0);
    send_fields(REQ_COLUMN, 4096, 4096, 4096, 0, 0, 0, 0);
    send_fields(REQ_TRANS, 0, 0, 0, 32'sd1000000, -32'sd123456, 32'sd77, 20'sd40960);
    pause_until_drained();

    seq_count = 0;
    while (items_sent < 1270) begin
      no_idle = (items_sent >= 500 && items_sent < 750);
      if ($urandom_range(0, 99) < 80) begin
        n_rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 3;
        n_cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 3;
        repeat (n_rows) send_item(make_item(REQ_LIGHT));
        repeat (n_cols) send_item(make_item(REQ_COLUMN));
        if ($urandom_range(0, 9) != 0)
          send_item(make_item(REQ_TRANS));
      end else begin
        // stray transactions of any type, the ignored one among them
        repeat ($urandom_range(1, 4)) send_item(make_item(2'($urandom_range(0, 3))));
      end
      seq_count++;
      if (seq_count % 25 == 24)
        pause_until_drained();
    end

    start <= 1'b0;
    @(posedge clk);
    while (book.pending_shadows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.pending_shadows.size() != 0)
      book.report($sformatf("%0d results never arrived", book.pending_shadows.size()));

    $display("covered %0d transactions (%0d of the ignored type), %0d results checked",
             items_sent, book.ignored_count, book.results_seen);
    $display("%0d results were sheared by a light with negative y", book.sheared_count);
    if (book.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(64'd6_000_000);
    $display("timeout with %0d results outstanding", book.pending_shadows.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
